/* rtl/wrx_pkg.sv */
// Shared constants, types and the rotate-xor step of the Weyl rotate-xor generator.
package wrx_pkg;

  localparam int NSTG          = 5;   // pipeline stages, two rotate-xor steps each
  localparam int NSTEP         = 10;
  localparam int MID_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF = 8;

  localparam logic REQ_WORD = 1'b0;
  localparam logic REQ_BITS = 1'b1;

  localparam logic [6:0] NBITS_MAX = 7'd64;

  localparam logic [63:0] INC_HI      = 64'hE7866D8CFFF116AA;
  localparam logic [63:0] INC_LO      = 64'hA933E07E1CB7963D;
  localparam logic [63:0] SEED_MUL_LO = 64'hAD62418D14EA8247;
  localparam logic [63:0] SEED_ADD_LO = 64'h01C4B4886CC66F59;
  localparam logic [63:0] SEED_MUL_HI = 64'hFFD1390A0ADC2FB8;
  localparam logic [63:0] SEED_ADD_HI = 64'hDABBB8174D95C99B;

  localparam logic [63:0] STEP_C [NSTEP] = '{
    64'hf3dd0fb7820fde37, 64'he6c6ac2c59e52811, 64'h2fc7871fff7c5b45,
    64'h47c7e1f70aa4f7c5, 64'h094f02b7fb9ba895, 64'h89afda817e744570,
    64'hc7277d052c7bf14b, 64'h474f4433b10b081d, 64'ha0a543d9f16196a5,
    64'h06dce455629a8955
  };

  // low bit of the 6-bit rotate amount taken from the fold, per step
  localparam int STEP_SLICE [NSTEP] = '{24, 6, 18, 48, 0, 12, 36, 54, 28, 10};

  // one classified request as it travels from front to back
  typedef struct packed {
    logic [63:0] fold;      // counter halves XORed; don't care when need is low
    logic        need;      // a fresh word was drawn for this request
    logic        req_type;
    logic [6:0]  nbits;     // already saturated to 64
  } wrx_req_t;

  function automatic logic [63:0] rot_xor(input logic [63:0] t, input logic [63:0] s,
                                          input int k);
    logic [5:0]   n;
    logic [127:0] tt;
    n  = s[STEP_SLICE[k] +: 6];
    tt = {t, t} << n;
    return tt[127:64] ^ STEP_C[k];
  endfunction

endpackage

/* rtl/wrx_fifo.sv */
// Small register queue with occupancy count.
module wrx_fifo
  import wrx_pkg::*;
#(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == CW'(DEPTH));
  assign count   = cnt_r;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

/* rtl/wrx_front.sv */
// Front end: seed loading, 128-bit counter, pool-count tracking and request classification.
module wrx_front
  import wrx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [63:0] cfg_seed,
  input  logic       in_push,
  output logic       in_full,
  input  logic       in_req_type,
  input  logic [6:0] in_nbits,
  input  logic       mid_full,
  output logic       mid_push,
  output wrx_req_t   mid_req,
  output logic       cfg_we
);

  logic        busy_r;
  logic [2:0]  bidx_r;
  logic [63:0] seed_r;
  logic [63:0] ctr_lo_r, ctr_lo_nxt, ctr_hi_r, ctr_hi_nxt;
  logic [6:0]  pcnt_r, pcnt_nxt;

  logic [64:0] lo_sum;
  logic [63:0] hi_sum, fold;
  logic [63:0] prod_lo, prod_hi;
  logic [7:0]  seed_byte;
  logic [6:0]  n_sat;
  logic        need, accept;

  assign cfg_ready = !busy_r;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign in_full   = busy_r || mid_full;
  assign accept    = in_push && !in_full;
  assign mid_push  = accept;

  // next Weyl step and its fold
  assign lo_sum = {1'b0, ctr_lo_r} + {1'b0, INC_LO};
  assign hi_sum = ctr_hi_r + INC_HI + {63'd0, lo_sum[64]};
  assign fold   = hi_sum ^ lo_sum[63:0];

  // seed multiply, one byte of the seed per cycle
  assign seed_byte = seed_r[{bidx_r, 3'b000} +: 8];
  assign prod_lo   = (SEED_MUL_LO * {56'd0, seed_byte}) << {bidx_r, 3'b000};
  assign prod_hi   = (SEED_MUL_HI * {56'd0, seed_byte}) << {bidx_r, 3'b000};

  always_comb begin
    n_sat    = (in_nbits > NBITS_MAX) ? NBITS_MAX : in_nbits;
    need     = (in_req_type == REQ_WORD) || (n_sat > pcnt_r);
    pcnt_nxt = pcnt_r;
    if (in_req_type == REQ_BITS) begin
      pcnt_nxt = (need ? NBITS_MAX : pcnt_r) - n_sat;
    end
    mid_req.fold     = fold;
    mid_req.need     = need;
    mid_req.req_type = in_req_type;
    mid_req.nbits    = n_sat;
  end

  always_comb begin
    ctr_lo_nxt = ctr_lo_r;
    ctr_hi_nxt = ctr_hi_r;
    if (cfg_we) begin
      ctr_lo_nxt = SEED_ADD_LO;
      ctr_hi_nxt = SEED_ADD_HI;
    end else if (busy_r) begin
      ctr_lo_nxt = ctr_lo_r + prod_lo;
      ctr_hi_nxt = ctr_hi_r + prod_hi;
    end else if (accept && need) begin
      ctr_lo_nxt = lo_sum[63:0];
      ctr_hi_nxt = hi_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      bidx_r   <= '0;
      pcnt_r   <= '0;
      ctr_lo_r <= SEED_ADD_LO;
      ctr_hi_r <= SEED_ADD_HI;
    end else begin
      ctr_lo_r <= ctr_lo_nxt;
      ctr_hi_r <= ctr_hi_nxt;
      if (cfg_we) begin
        busy_r <= 1'b1;
        bidx_r <= '0;
        pcnt_r <= '0;
      end else if (busy_r) begin
        bidx_r <= bidx_r + 1'b1;
        if (bidx_r == 3'd7) begin
          busy_r <= 1'b0;
        end
      end else if (accept) begin
        pcnt_r <= pcnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_we) begin
      seed_r <= cfg_seed;
    end
  end

endmodule

/* rtl/wrx_back.sv */
// Back end: rotate-xor pipeline, bit pool and result queue credit.
module wrx_back
  import wrx_pkg::*;
#(
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           pool_clr,
  input  wrx_req_t                       mid_req,
  input  logic                           mid_empty,
  output logic                           mid_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
  output logic                           res_push,
  output logic [63:0]                    res_data
);

  localparam int CW = $clog2(OUT_DEPTH + NSTG + 1);

  wrx_req_t    st_req_r [NSTG];
  logic [63:0] st_t_r   [NSTG];
  logic [NSTG-1:0] st_v_r;

  wrx_req_t    in_req [NSTG];
  logic [63:0] in_t   [NSTG];
  logic [NSTG-1:0] in_v;

  logic [63:0] pool_r, pool_nxt;
  logic [63:0] word, pw, mask;
  logic [CW-1:0] used;
  wrx_req_t    last;

  // launch only when every item in flight already has a result slot
  assign used    = CW'(out_count) + CW'($countones(st_v_r));
  assign mid_pop = !mid_empty && (used < CW'(OUT_DEPTH));

  for (genvar g = 0; g < NSTG; g++) begin : g_stg
    if (g == 0) begin : g_head
      assign in_req[g] = mid_req;
      assign in_t[g]   = mid_req.fold;
      assign in_v[g]   = mid_pop;
    end else begin : g_body
      assign in_req[g] = st_req_r[g-1];
      assign in_t[g]   = st_t_r[g-1];
      assign in_v[g]   = st_v_r[g-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_v_r <= '0;
    end else begin
      st_v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NSTG; i++) begin
      st_req_r[i] <= in_req[i];
      st_t_r[i]   <= rot_xor(rot_xor(in_t[i], in_req[i].fold, 2*i),
                             in_req[i].fold, 2*i+1);
    end
  end

  assign last     = st_req_r[NSTG-1];
  assign word     = st_t_r[NSTG-1];
  assign res_push = st_v_r[NSTG-1];

  always_comb begin
    pw       = last.need ? word : pool_r;
    mask     = last.nbits[6] ? '1 : ((64'd1 << last.nbits[5:0]) - 64'd1);
    pool_nxt = pool_r;
    if (last.req_type == REQ_WORD) begin
      res_data = word;
    end else begin
      res_data = pw & mask;
      pool_nxt = last.nbits[6] ? '0 : (pw >> last.nbits[5:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r <= '0;
    end else if (pool_clr) begin
      pool_r <= '0;
    end else if (res_push) begin
      pool_r <= pool_nxt;
    end
  end

endmodule

/* rtl/weyl_rotate_xor_rng_bit_pool.sv */
// Top level of the Weyl rotate-xor random generator with bit pool.
//
//   channel  handshake             payload
//   in       in_push / in_full     in_req_type, in_nbits
//   out      out_pop / out_empty   out_value
//   cfg      cfg_valid / cfg_ready cfg_seed
//
// One request per cycle sustained while out_pop keeps up and no seed write is running;
// a result reaches out_* through the request queue, five rotate-xor stages of two steps
// each and the result queue. A seed write runs a byte-serial seed multiply; in_full is
// high and cfg_ready low meanwhile. Reset loads the counter for seed zero and empties
// the pool. Stalls on out_pop back up through the result queue credit into in_full.
module weyl_rotate_xor_rng_bit_pool
  import wrx_pkg::*;
#(
  parameter int MID_DEPTH = MID_DEPTH_DEF,
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_seed,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_req_type,
  input  logic [6:0]  in_nbits,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [63:0] out_value
);

  wrx_req_t mid_wreq, mid_rreq;
  logic     mid_push, mid_pop, mid_full, mid_empty, cfg_we;
  logic     res_push;
  logic [63:0] res_data;
  logic [$clog2(OUT_DEPTH+1)-1:0] out_count;

  wrx_front u_front (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_seed,
    .in_push, .in_full, .in_req_type, .in_nbits,
    .mid_full, .mid_push, .mid_req(mid_wreq), .cfg_we
  );

  wrx_fifo #(.WIDTH($bits(wrx_req_t)), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk, .rst_n, .push(mid_push), .wdata(mid_wreq), .pop(mid_pop),
    .rdata(mid_rreq), .empty(mid_empty), .full(mid_full), .count()
  );

  wrx_back #(.OUT_DEPTH(OUT_DEPTH)) u_back (
    .clk, .rst_n, .pool_clr(cfg_we), .mid_req(mid_rreq), .mid_empty, .mid_pop,
    .out_count, .res_push, .res_data
  );

  // credit guarantees no push into a full result queue
  wrx_fifo #(.WIDTH(64), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk, .rst_n, .push(res_push), .wdata(res_data), .pop(out_pop),
    .rdata(out_value), .empty(out_empty), .full(), .count(out_count)
  );

endmodule

/* rtl/wrx_chk.sv */
// Port-level checker for the generator, bound to the top level.
module wrx_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic        in_full,
  input logic        out_empty,
  input logic        out_pop,
  input logic [63:0] out_value
);

  // a seed write is followed by busy: cfg_ready low and in_full high
  a_seed_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> !cfg_ready && in_full)
    else $error("seed write not followed by busy");

  a_busy_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_ready |-> in_full)
    else $error("request taken during seed load");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty && cfg_ready)
    else $error("results or busy left after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_value))
    else $error("stalled result changed");

endmodule

bind weyl_rotate_xor_rng_bit_pool wrx_chk u_chk (.*);

/* sim/tb_top.sv */
// Self-checking testbench for the Weyl rotate-xor generator with its bit pool.
module tb_top;

  localparam logic [63:0] WEYL_INC_HI = 64'hE7866D8CFFF116AA;
  localparam logic [63:0] WEYL_INC_LO = 64'hA933E07E1CB7963D;
  localparam logic [63:0] SEEDING_MUL_LO = 64'hAD62418D14EA8247;
  localparam logic [63:0] SEEDING_ADD_LO = 64'h01C4B4886CC66F59;
  localparam logic [63:0] SEEDING_MUL_HI = 64'hFFD1390A0ADC2FB8;
  localparam logic [63:0] SEEDING_ADD_HI = 64'hDABBB8174D95C99B;

  localparam logic [63:0] STAGE_XOR [10] = '{
    64'hf3dd0fb7820fde37, 64'he6c6ac2c59e52811, 64'h2fc7871fff7c5b45,
    64'h47c7e1f70aa4f7c5, 64'h094f02b7fb9ba895, 64'h89afda817e744570,
    64'hc7277d052c7bf14b, 64'h474f4433b10b081d, 64'ha0a543d9f16196a5,
    64'h06dce455629a8955
  };
  localparam int STAGE_SHIFT_POS [10] = '{24, 6, 18, 48, 0, 12, 36, 54, 28, 10};

  localparam logic [6:0] FULL_WIDTH = 7'd64;

  // Predicts the value stream and checks what the block returns.
  class rng_scoreboard;
    logic [63:0] weyl_lo;
    logic [63:0] weyl_hi;
    logic [63:0] pool;
    int unsigned pool_bits;
    logic [63:0] expected_values[$];
    int unsigned mismatches;
    int unsigned checked;

    function void reseed(input logic [63:0] s);
      weyl_lo   = s * SEEDING_MUL_LO + SEEDING_ADD_LO;
      weyl_hi   = s * SEEDING_MUL_HI + SEEDING_ADD_HI;
      pool      = '0;
      pool_bits = 0;
    endfunction

    function logic [63:0] next_word();
      logic [127:0] sum;
      logic [63:0]  fold;
      logic [63:0]  t;
      logic [5:0]   amt;
      sum     = {weyl_hi, weyl_lo} + {WEYL_INC_HI, WEYL_INC_LO};
      weyl_hi = sum[127:64];
      weyl_lo = sum[63:0];
      fold    = weyl_hi ^ weyl_lo;
      t       = fold;
      for (int i = 0; i < 10; i++) begin
        amt = fold[STAGE_SHIFT_POS[i] +: 6];
        if (amt != 6'd0) t = (t << amt) | (t >> (64 - int'(amt)));
        t = t ^ STAGE_XOR[i];
      end
      return t;
    endfunction

    function void note_request(input logic rt, input logic [6:0] nb);
      logic [6:0]  n;
      logic [63:0] v;
      if (rt == wrx_pkg::REQ_WORD) begin
        v = next_word();
      end else begin
        n = (nb > FULL_WIDTH) ? FULL_WIDTH : nb;
        // too few bits left: old pool contents are thrown away
        if (n > pool_bits) begin
          pool      = next_word();
          pool_bits = 64;
        end
        if (n == FULL_WIDTH) begin
          v    = pool;
          pool = '0;
        end else begin
          v    = pool & ((64'd1 << n) - 64'd1);
          pool = pool >> n;
        end
        pool_bits -= n;
      end
      expected_values.push_back(v);
    endfunction

    function void check_value(input logic [63:0] got);
      logic [63:0] want;
      checked++;
      if (expected_values.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, got);
        mismatches++;
      end else begin
        want = expected_values.pop_front();
        if (got !== want) begin
          $display("%0t: value mismatch, expected %h actual %h", $time, want, got);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [63:0] cfg_seed = '0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic        in_req_type = 1'b0;
  logic [6:0]  in_nbits = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [63:0] out_value;

  rng_scoreboard sb;
  bit          calm = 1'b0;
  int unsigned word_reqs = 0;
  int unsigned bit_reqs = 0;
  int unsigned seed_writes = 0;

  always #6 clk = ~clk;

  weyl_rotate_xor_rng_bit_pool i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_seed   (cfg_seed),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_req_type(in_req_type),
    .in_nbits   (in_nbits),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_value  (out_value)
  );

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 9);
  endfunction

  // Called at a falling edge; returns at a falling edge with in_push still high.
  task automatic send_request(input logic rt, input logic [6:0] nb);
    while (idle_now()) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push     <= 1'b1;
    in_req_type <= rt;
    in_nbits    <= nb;
    do @(posedge clk); while (in_full);
    sb.note_request(rt, nb);
    if (rt == wrx_pkg::REQ_WORD) word_reqs++;
    else bit_reqs++;
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    in_push <= 1'b0;
    while (sb.expected_values.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_seed(input logic [63:0] s);
    cfg_valid <= 1'b1;
    cfg_seed  <= s;
    do @(posedge clk); while (!cfg_ready);
    sb.reseed(s);
    seed_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic directed_requests();
    logic [7:0] plan [22] = '{
      {wrx_pkg::REQ_WORD, 7'd0},   {wrx_pkg::REQ_WORD, 7'd127},
      {wrx_pkg::REQ_BITS, 7'd0},   {wrx_pkg::REQ_BITS, 7'd1},
      {wrx_pkg::REQ_BITS, 7'd63},  {wrx_pkg::REQ_BITS, 7'd1},
      {wrx_pkg::REQ_BITS, 7'd64},  {wrx_pkg::REQ_BITS, 7'd64},
      {wrx_pkg::REQ_BITS, 7'd127}, {wrx_pkg::REQ_BITS, 7'd65},
      {wrx_pkg::REQ_BITS, 7'd5},   {wrx_pkg::REQ_WORD, 7'd64},
      {wrx_pkg::REQ_BITS, 7'd0},   {wrx_pkg::REQ_BITS, 7'd59},
      {wrx_pkg::REQ_BITS, 7'd60},  {wrx_pkg::REQ_BITS, 7'd3},
      {wrx_pkg::REQ_BITS, 7'd100}, {wrx_pkg::REQ_BITS, 7'd32},
      {wrx_pkg::REQ_BITS, 7'd32},  {wrx_pkg::REQ_BITS, 7'd33},
      {wrx_pkg::REQ_WORD, 7'd85},  {wrx_pkg::REQ_BITS, 7'd7}
    };
    foreach (plan[i]) send_request(plan[i][7], plan[i][6:0]);
  endtask

  function automatic logic [6:0] pick_width();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 7'd0;
    if (r < 20) return FULL_WIDTH;
    if (r < 35) return 7'($urandom_range(127, 65));
    return 7'($urandom_range(63, 1));
  endfunction

  task automatic random_phase(input int count);
    int sent;
    int remaining;
    int sz;
    sent = 0;
    while (sent < count) begin
      if (sent >= count / 2 && sent < count / 2 + 2) hold_until_drained();
      if ($urandom_range(2) == 0) begin
        // pieces that empty a full pool exactly, now and then a whole word between them
        remaining = 64;
        while (remaining > 0 && sent < count) begin
          if ($urandom_range(7) == 0) begin
            send_request(wrx_pkg::REQ_WORD, 7'($urandom_range(127)));
          end else begin
            sz = $urandom_range(remaining > 16 ? 16 : remaining, 1);
            send_request(wrx_pkg::REQ_BITS, 7'(sz));
            remaining -= sz;
          end
          sent++;
        end
      end else begin
        if ($urandom_range(1) == 0) send_request(wrx_pkg::REQ_WORD, 7'($urandom_range(127)));
        else send_request(wrx_pkg::REQ_BITS, pick_width());
        sent++;
      end
    end
  endtask

  // result side: random stalls on pop
  initial begin
    forever begin
      @(negedge clk);
      out_pop <= !idle_now();
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) sb.check_value(out_value);
    end
  end

  initial begin
    #2400000;
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    logic [63:0] seeds [6];
    sb = new();
    sb.reseed(64'd0);
    seeds[0] = 64'hFFFF_FFFF_FFFF_FFFF;
    seeds[1] = 64'd0;
    seeds[2] = {$urandom, $urandom};
    seeds[3] = 64'd1;
    seeds[4] = {$urandom, $urandom};
    seeds[5] = 64'h8000_0000_0000_0000;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    directed_requests();
    hold_until_drained();
    foreach (seeds[p]) begin
      calm = (p == 2);
      write_seed(seeds[p]);
      random_phase(305);
      hold_until_drained();
    end
    calm = 1'b0;
    repeat (20) @(posedge clk);
    $display("Covered %0d whole-word and %0d pool requests over %0d seed writes,",
             word_reqs, bit_reqs, seed_writes);
    $display("with %0d results compared and random stalls on both sides.", sb.checked);
    if (sb.mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
